// ----- sv/rvs_pkg.sv -----
package rvs_pkg;

  localparam int unsigned VAL_W = 3;
  localparam int unsigned SET_W = 11;
  localparam int unsigned WAY_W = 4;
  localparam int unsigned RND_W = 16;
  // Divisor width of the remainder unit: enough for any set count
  localparam int unsigned DIV_W = 17;

  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [VAL_W-1:0] HIT_VALUE  = 3'd7;
  localparam logic [VAL_W-1:0] FILL_VALUE = 3'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

// ----- sv/rvs_rem_unit.sv -----
module rvs_rem_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rvs_pkg::RND_W-1:0]      dividend_i,
  input  logic [rvs_pkg::DIV_W-1:0]      divisor_i,
  output rvs_pkg::rem_stat_t             stat_o,
  output logic [rvs_pkg::DIV_W-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(rvs_pkg::RND_W + 1);

  logic [rvs_pkg::DIV_W-1:0] rem_q, rem_d;
  logic [rvs_pkg::RND_W-1:0] dvd_q, dvd_d;
  logic [rvs_pkg::DIV_W-1:0] div_q, div_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [rvs_pkg::DIV_W:0]   trial;

  // Restoring remainder, one dividend bit a cycle, MSB first
  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[rvs_pkg::RND_W-1]};
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = CNT_W'(rvs_pkg::RND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      rem_d = trial[rvs_pkg::DIV_W-1:0];
      dvd_d = {dvd_q[rvs_pkg::RND_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

// ----- sv/rrip_victim_selector.sv -----
// RRIP-style victim selector with inverted 3-bit per-way values (0 = evict first). Each set
// row sits in one memory word. After reset a clearing pass writes every row to zero, one row
// a cycle, and no request is taken meanwhile. An update (hit or fill) goes through accept,
// row read and row write. A find-victim request goes through row read, ageing write-back,
// zero count, a bit-serial remainder of random_value by the zero count, then a scan of one
// way a cycle up to the victim. A set_index of SETS or more first goes through the same
// remainder unit. The victim waits in an output register, so the next request is taken
// while it is still stalled.
module rrip_victim_selector #(
  parameter int unsigned SETS = 2048,
  parameter int unsigned WAYS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [rvs_pkg::SET_W-1:0]     set_index_i,
  input  logic [rvs_pkg::WAY_W-1:0]     way_index_i,
  input  logic                          was_hit_i,
  input  logic                          is_writeback_i,
  input  logic [rvs_pkg::RND_W-1:0]     random_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rvs_pkg::WAY_W-1:0]     victim_way_o
);

  localparam int unsigned VW    = rvs_pkg::VAL_W;
  localparam int unsigned DW    = rvs_pkg::DIV_W;
  localparam int unsigned AW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW    = $clog2(WAYS);
  localparam int unsigned CW    = $clog2(WAYS + 1);
  localparam int unsigned ROW_W = WAYS * VW;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SMOD = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_ROW  = 3'd4;
  localparam logic [2:0] S_CNT  = 3'd5;
  localparam logic [2:0] S_RMOD = 3'd6;
  localparam logic [2:0] S_SCAN = 3'd7;

  logic [2:0]                state_q, state_d;
  logic [AW-1:0]             clr_q, clr_d;
  logic [AW-1:0]             set_q, set_d;
  logic                      op_q;
  logic [rvs_pkg::WAY_W-1:0] way_q;
  logic                      hit_q;
  logic                      wb_q;
  logic [rvs_pkg::RND_W-1:0] rnd_q;
  logic [ROW_W-1:0]          rd_q;
  logic [ROW_W-1:0]          row_q, row_d;
  logic [WW-1:0]             wcnt_q, wcnt_d;
  logic [CW-1:0]             kth_q, kth_d;
  logic                      out_valid_q, out_valid_d;
  logic [rvs_pkg::WAY_W-1:0] victim_q, victim_d;

  logic                      accept;
  logic                      out_free;
  logic [DW-1:0]             sets_c;
  logic [5:0]                ways_c;
  logic                      set_in_range;

  logic                      mem_we;
  logic [AW-1:0]             mem_wa;
  logic [ROW_W-1:0]          mem_wd;
  logic [ROW_W-1:0]          mem_q [SETS];

  logic                      rem_start;
  logic [rvs_pkg::RND_W-1:0] rem_dividend;
  logic [DW-1:0]             rem_divisor;
  rvs_pkg::rem_stat_t        rem_stat;
  logic [DW-1:0]             rem_val;

  logic [7:0]                has_val;
  logic [VW-1:0]             min_val;
  logic [ROW_W-1:0]          aged_row;
  logic [ROW_W-1:0]          upd_row;
  logic [VW-1:0]             upd_val;
  logic                      upd_en;
  logic [WAYS-1:0]           zmask;
  logic [CW-1:0]             zcnt;

  assign sets_c       = SETS[DW-1:0];
  assign ways_c       = WAYS[5:0];
  assign set_in_range = {{(DW - rvs_pkg::SET_W){1'b0}}, set_index_i} < sets_c;
  assign in_stall_o   = (state_q != S_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;

  // Smallest value present in the read row, then the row aged by it
  always_comb begin
    has_val = '0;
    for (int w = 0; w < WAYS; w++) begin
      for (int v = 0; v < 8; v++) begin
        if (rd_q[w*VW +: VW] == VW'(v)) begin
          has_val[v] = 1'b1;
        end
      end
    end
    min_val = '0;
    for (int v = 7; v >= 0; v--) begin
      if (has_val[v]) begin
        min_val = VW'(v);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      aged_row[w*VW +: VW] = rd_q[w*VW +: VW] - min_val;
    end
  end

  always_comb begin
    upd_val = hit_q ? rvs_pkg::HIT_VALUE : rvs_pkg::FILL_VALUE;
    upd_en  = ({2'b00, way_q} < ways_c) && !(hit_q && wb_q);
    for (int w = 0; w < WAYS; w++) begin
      upd_row[w*VW +: VW] = (6'(w) == {2'b00, way_q}) ? upd_val : rd_q[w*VW +: VW];
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      zmask[w] = (row_q[w*VW +: VW] == '0);
    end
    zcnt = CW'($countones(zmask));
  end

  // Remainder unit serves both the set wrap and the random pick
  always_comb begin
    rem_start    = 1'b0;
    rem_dividend = random_value_i;
    rem_divisor  = sets_c;
    if (state_q == S_IDLE) begin
      rem_start    = accept && !set_in_range;
      rem_dividend = {{(rvs_pkg::RND_W - rvs_pkg::SET_W){1'b0}}, set_index_i};
    end else if (state_q == S_CNT) begin
      rem_start    = 1'b1;
      rem_dividend = rnd_q;
      rem_divisor  = DW'(zcnt);
    end
  end

  rvs_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (rem_divisor),
    .stat_o     (rem_stat),
    .rem_o      (rem_val)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    set_d       = set_q;
    row_d       = row_q;
    wcnt_d      = wcnt_q;
    kth_d       = kth_q;
    out_valid_d = out_valid_q && out_stall_i;
    victim_d    = victim_q;
    mem_we      = 1'b0;
    mem_wa      = set_q;
    mem_wd      = aged_row;
    unique case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == AW'(SETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          set_d   = AW'({{(DW - rvs_pkg::SET_W){1'b0}}, set_index_i});
          state_d = set_in_range ? S_READ : S_SMOD;
        end
      end
      S_SMOD: begin
        if (rem_stat.done) begin
          set_d   = rem_val[AW-1:0];
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_ROW;
      end
      S_ROW: begin
        if (op_q == rvs_pkg::OP_UPDATE) begin
          mem_we  = upd_en;
          mem_wd  = upd_row;
          state_d = S_IDLE;
        end else begin
          mem_we  = (min_val != '0);
          row_d   = aged_row;
          state_d = S_CNT;
        end
      end
      S_CNT: begin
        state_d = S_RMOD;
      end
      S_RMOD: begin
        if (rem_stat.done) begin
          kth_d   = rem_val[CW-1:0];
          wcnt_d  = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (zmask[wcnt_q] && kth_q == '0) begin
          // hold the victim until the output register frees up
          if (out_free) begin
            out_valid_d = 1'b1;
            victim_d    = 4'(wcnt_q);
            state_d     = S_IDLE;
          end
        end else begin
          if (zmask[wcnt_q]) begin
            kth_d = kth_q - 1'b1;
          end
          wcnt_d = wcnt_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q    <= set_d;
    row_q    <= row_d;
    wcnt_q   <= wcnt_d;
    kth_q    <= kth_d;
    victim_q <= victim_d;
    if (accept) begin
      op_q  <= operation_i;
      way_q <= way_index_i;
      hit_q <= was_hit_i;
      wb_q  <= is_writeback_i;
      rnd_q <= random_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[set_q];
  end

  assign out_valid_o  = out_valid_q;
  assign victim_way_o = victim_q;

`ifndef SYNTHESIS
  a_clr_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_CLR |=> state_q != S_CLR)
    else $error("clearing pass re-entered");

  a_rem_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_stat.done |-> (state_q == S_SMOD || state_q == S_RMOD))
    else $error("remainder result with no waiting state");

  a_rem_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !rem_stat.busy)
    else $error("remainder unit busy while idle");

  a_zero_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CNT |-> zmask != '0)
    else $error("aged row holds no evictable way");

  a_mem_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLR || state_q == S_ROW))
    else $error("row write outside clear or row step");
`endif

endmodule
